// ===== rtl/lrupr_pkg.sv =====
// Shared constants for the LRU page replacement block.
package lrupr_pkg;

  localparam int STAMP_W     = 32;
  localparam int COUNT_W     = 32;
  localparam int CFG_W       = 4;
  localparam int IN_PAGE_W   = 16;
  localparam int OUT_FRAME_W = 3;
  localparam int OUT_PAGE_W  = 16;
  localparam int OUT_DATA_W  = 88;
  localparam int OUT_USER_W  = 2;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement: one page reference in, one hit/fault result out.
// Each reference is handled in order: the frame memory is scanned one entry per cycle through its
// single read port over the clamped frames_in_use entries, the last read drains, and the chosen
// frame is written back. A new reference is taken only after the last one is written back, which
// waits while a finished result is still held waiting on out_tready.
// Reset (synchronous, rst_n low) clears all frames to empty, the stamp counter to one,
// both totals to zero and frames_in_use to 8; the frame memory itself is not cleared.
module lru_page_replacement
  import lrupr_pkg::*;
#(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,   // frames_in_use
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_PAGE_W-1:0]  in_tdata,      // page
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // frame[2:0], evicted_page[18:3], fault_count[50:19], reference_count[82:51], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser      // hit[0], evicted_valid[1]
);

  localparam int IDXW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNTW = $clog2(FRAMES + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     cfg_r;
  logic [FRAMES-1:0]    valid_r;
  logic [STAMP_W-1:0]   next_stamp_r;
  logic [COUNT_W-1:0]   faults_r;
  logic [COUNT_W-1:0]   refs_r;

  logic [PAGE_BITS-1:0] page_r;
  logic [CNTW-1:0]      active_r;
  logic [CNTW-1:0]      rd_cnt_r;
  logic                 rd_vld_r;
  logic [IDXW-1:0]      rd_idx_r;
  logic                 hit_r;
  logic [IDXW-1:0]      hit_idx_r;
  logic [IDXW-1:0]      min_idx_r;
  logic [STAMP_W-1:0]   min_stamp_r;
  logic [PAGE_BITS-1:0] min_page_r;

  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_ev_valid_r;
  logic [OUT_FRAME_W-1:0] out_frame_r;
  logic [OUT_PAGE_W-1:0]  out_ev_page_r;
  logic [COUNT_W-1:0]   out_faults_r;
  logic [COUNT_W-1:0]   out_refs_r;

  logic [CNTW-1:0]      active_cfg;
  logic                 rd_issue;
  logic [PAGE_BITS-1:0] rd_page;
  logic [STAMP_W-1:0]   rd_stamp;
  logic [STAMP_W-1:0]   stamp_eff;
  logic                 entry_valid;
  logic                 upd_go;
  logic [IDXW-1:0]      slot;
  logic                 ev_valid;
  logic                 in_xfer;

  // Clamp the frame count into the range one to FRAMES.
  always_comb begin
    if (cfg_r == '0) begin
      active_cfg = CNTW'(1);
    end else if (32'(cfg_r) > FRAMES) begin
      active_cfg = CNTW'(FRAMES);
    end else begin
      active_cfg = CNTW'(cfg_r);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign rd_issue  = (state_r == ST_SCAN) && (rd_cnt_r < active_r);
  assign upd_go    = (state_r == ST_UPD) && (!out_valid_r || out_tready);

  // An empty frame reads as stamp zero, below every stored stamp, since stamps start at one.
  assign entry_valid = valid_r[rd_idx_r];
  assign stamp_eff   = entry_valid ? rd_stamp : '0;

  assign slot     = hit_r ? hit_idx_r : min_idx_r;
  assign ev_valid = !hit_r && valid_r[min_idx_r];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!rd_issue && !rd_vld_r) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  lrupr_frame_ram #(
    .DEPTH     (FRAMES),
    .PAGE_BITS (PAGE_BITS),
    .IDXW      (IDXW)
  ) u_ram (
    .clk      (clk),
    .wr_en    (upd_go),
    .wr_addr  (slot),
    .wr_page  (page_r),
    .wr_stamp (next_stamp_r),
    .rd_addr  (rd_cnt_r[IDXW-1:0]),
    .rd_page  (rd_page),
    .rd_stamp (rd_stamp)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cfg_r        <= CFG_RESET;
      valid_r      <= '0;
      next_stamp_r <= STAMP_W'(1);
      faults_r     <= '0;
      refs_r       <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_issue;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (upd_go) begin
        valid_r[slot] <= 1'b1;
        if (next_stamp_r != STAMP_MAX) begin
          next_stamp_r <= next_stamp_r + 1'b1;
        end
        if (!hit_r && faults_r != COUNT_MAX) begin
          faults_r <= faults_r + 1'b1;
        end
        if (refs_r != COUNT_MAX) begin
          refs_r <= refs_r + 1'b1;
        end
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Scan datapath and result register.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      page_r   <= PAGE_BITS'(in_tdata);
      active_r <= active_cfg;
      rd_cnt_r <= '0;
      hit_r    <= 1'b0;
    end else if (rd_issue) begin
      rd_cnt_r <= rd_cnt_r + 1'b1;
    end
    rd_idx_r <= rd_cnt_r[IDXW-1:0];

    if (rd_vld_r) begin
      // First match wins; least stamp keeps the lowest index on ties.
      if (entry_valid && rd_page == page_r && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (rd_idx_r == '0 || stamp_eff < min_stamp_r) begin
        min_idx_r   <= rd_idx_r;
        min_stamp_r <= stamp_eff;
        min_page_r  <= rd_page;
      end
    end

    if (upd_go) begin
      out_hit_r      <= hit_r;
      out_frame_r    <= OUT_FRAME_W'(slot);
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= ev_valid ? OUT_PAGE_W'(min_page_r) : '0;
      out_faults_r   <= (!hit_r && faults_r != COUNT_MAX) ? faults_r + 1'b1 : faults_r;
      out_refs_r     <= (refs_r != COUNT_MAX) ? refs_r + 1'b1 : refs_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_refs_r, out_faults_r, out_ev_page_r, out_frame_r};
  assign out_tuser  = {out_ev_valid_r, out_hit_r};

endmodule

// ===== rtl/lrupr_frame_ram.sv =====
// Frame table memory: page number and use stamp per frame, registered read.
module lrupr_frame_ram
  import lrupr_pkg::*;
#(
  parameter int DEPTH     = 8,
  parameter int PAGE_BITS = 16,
  parameter int IDXW      = 3
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDXW-1:0]      wr_addr,
  input  logic [PAGE_BITS-1:0] wr_page,
  input  logic [STAMP_W-1:0]   wr_stamp,
  input  logic [IDXW-1:0]      rd_addr,
  output logic [PAGE_BITS-1:0] rd_page,
  output logic [STAMP_W-1:0]   rd_stamp
);

  logic [PAGE_BITS+STAMP_W-1:0] mem [DEPTH];
  logic [PAGE_BITS+STAMP_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_page, wr_stamp};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_page  = rd_data_r[PAGE_BITS+STAMP_W-1:STAMP_W];
  assign rd_stamp = rd_data_r[STAMP_W-1:0];

endmodule

// ===== verif/lru_page_replacement_tb.sv =====
// Self-checking testbench for the LRU page replacement block with a built-in LRU predictor.
`timescale 1ns / 100ps

module lru_page_replacement_tb;
  import lrupr_pkg::*;

  localparam int FRAMES      = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 14;
  localparam int PHASE_PAGES = 100;

  typedef struct packed {
    logic                   hit;
    logic [OUT_FRAME_W-1:0] frame;
    logic                   evicted_valid;
    logic [OUT_PAGE_W-1:0]  evicted_page;
    logic [COUNT_W-1:0]     fault_count;
    logic [COUNT_W-1:0]     reference_count;
  } page_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_PAGE_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  lru_page_replacement #(
    .FRAMES(FRAMES),
    .PAGE_BITS(IN_PAGE_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Predictor copy of the frame table and the frame count register.
  logic [IN_PAGE_W-1:0] resident_page [FRAMES];
  bit                   resident_valid [FRAMES];
  logic [STAMP_W-1:0]   use_stamp [FRAMES];
  logic [STAMP_W-1:0]   stamp_next;
  logic [COUNT_W-1:0]   fault_total;
  logic [COUNT_W-1:0]   reference_total;
  logic [CFG_W-1:0]     frames_setting;

  logic [IN_PAGE_W-1:0] pending_pages [$];
  page_outcome_t        pending_outcomes [$];

  int  pages_queued = 0;
  int  pages_accepted = 0;
  int  failures = 0;
  int  hits_seen = 0;
  int  faults_seen = 0;
  int  settings_written = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  bit  calm_phase = 1'b0;
  int  in_gap_left = 0;
  int  out_stall_left = 0;

  logic [CFG_W-1:0]     setting_plan [PHASES] = '{4'd8, 4'd1, 4'd15, 4'd3, 4'd0, 4'd8, 4'd5,
                                                  4'd9, 4'd2, 4'd7, 4'd4, 4'd8, 4'd6, 4'd1};
  logic [IN_PAGE_W-1:0] hot_pages [16];

  function automatic page_outcome_t lru_reference(logic [IN_PAGE_W-1:0] page);
    int            active;
    int            slot;
    page_outcome_t result;
    active = (frames_setting == 0) ? 1 :
             (frames_setting > FRAMES) ? FRAMES : int'(frames_setting);
    result = '0;
    slot = -1;
    for (int j = 0; j < active; j++) begin
      if (slot < 0 && resident_valid[j] && resident_page[j] == page) slot = j;
    end
    if (slot >= 0) begin
      result.hit = 1'b1;
    end else begin
      // Empty frames carry stamp zero, so they win; ties keep the lower index.
      slot = 0;
      for (int j = 1; j < active; j++) begin
        if (use_stamp[j] < use_stamp[slot]) slot = j;
      end
      if (resident_valid[slot]) begin
        result.evicted_valid = 1'b1;
        result.evicted_page  = resident_page[slot];
      end
      resident_page[slot]  = page;
      resident_valid[slot] = 1'b1;
      if (fault_total != COUNT_MAX) fault_total = fault_total + 1;
    end
    use_stamp[slot] = stamp_next;
    if (stamp_next != STAMP_MAX) stamp_next = stamp_next + 1;
    if (reference_total != COUNT_MAX) reference_total = reference_total + 1;
    result.frame           = slot[OUT_FRAME_W-1:0];
    result.fault_count     = fault_total;
    result.reference_count = reference_total;
    return result;
  endfunction

  function automatic int draw_wait();
    return calm_phase ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  task automatic push_page(logic [IN_PAGE_W-1:0] page);
    pending_pages.push_back(page);
    pages_queued++;
  endtask

  // Returns at a falling edge once every queued page has been taken and answered.
  task automatic wait_idle();
    @(negedge clk);
    while (pages_accepted != pages_queued || pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic write_frames(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_wr_en      <= 1'b1;
    cfg_wr_data    <= value;
    frames_setting  = value;
    settings_written++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, pending_outcomes.size());
      $display("** lru_page_replacement: FAILED **");
      $finish;
    end
  end

  // Sample both channels; predict on every input transfer, check every output transfer.
  always @(posedge clk) begin
    page_outcome_t want;
    if (rst_n) begin
      in_taken  = in_tvalid && in_tready;
      out_taken = out_tvalid && out_tready;
      if (in_taken) begin
        pending_outcomes.push_back(lru_reference(in_tdata));
        pages_accepted++;
      end
      if (out_taken) begin
        if (pending_outcomes.size() == 0) begin
          $error("result transfer with no reference outstanding");
          failures++;
        end else begin
          want = pending_outcomes.pop_front();
          if (out_tuser[0] === 1'b1) hits_seen++;
          else faults_seen++;
          check_field("hit", want.hit, out_tuser[0]);
          check_field("evicted_valid", want.evicted_valid, out_tuser[1]);
          check_field("frame", want.frame, out_tdata[2:0]);
          check_field("evicted_page", want.evicted_page, out_tdata[18:3]);
          check_field("fault_count", want.fault_count, out_tdata[50:19]);
          check_field("reference_count", want.reference_count, out_tdata[82:51]);
          check_field("zero fill", 32'd0, out_tdata[OUT_DATA_W-1:83]);
        end
      end
    end
  end

  // Input driver: holds each page until its transfer, then waits a drawn gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // Still waiting for the transfer.
    end else if (in_gap_left > 0) begin
      in_gap_left--;
      in_tvalid <= 1'b0;
    end else if (pending_pages.size() > 0) begin
      in_tdata    <= pending_pages.pop_front();
      in_tvalid   <= 1'b1;
      in_gap_left  = draw_wait();
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result side back-pressure: a drawn stall after each transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_taken) out_stall_left = draw_wait();
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int working_set;
    int pick;
    logic [IN_PAGE_W-1:0] page;

    for (int j = 0; j < FRAMES; j++) begin
      resident_page[j]  = '0;
      resident_valid[j] = 1'b0;
      use_stamp[j]      = '0;
    end
    stamp_next      = 1;
    fault_total     = '0;
    reference_total = '0;
    frames_setting  = CFG_RESET;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Fill all eight frames from empty, hit, then evict the least recently used.
    push_page(16'h0000);
    push_page(16'hFFFF);
    push_page(16'h0000);
    for (int p = 1; p <= 6; p++) push_page(p[IN_PAGE_W-1:0]);
    push_page(16'h0007);
    push_page(16'hFFFF);
    push_page(16'hAAAA);
    push_page(16'h5555);
    push_page(16'h0003);

    // A single frame: every new page replaces the one before.
    write_frames(4'd1);
    push_page(16'h1234);
    push_page(16'h1234);
    push_page(16'h4321);
    // Zero acts as one frame.
    write_frames(4'd0);
    push_page(16'h4321);
    push_page(16'h0003);
    // Values above the table size act as the full table; the idle frames kept their pages.
    write_frames(4'd15);
    push_page(16'h0005);
    push_page(16'hAAAA);
    push_page(16'h8000);
    write_frames(4'd9);
    push_page(16'h0001);
    push_page(16'h5555);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_frames((ph % 5 == 4) ? 4'($urandom_range(0, 15)) : setting_plan[ph]);
      calm_phase = ($urandom_range(0, 3) == 0);
      working_set = $urandom_range(2, 14);
      for (int j = 0; j < 16; j++) hot_pages[j] = 16'($urandom);
      if (ph % 3 == 0) hot_pages[0] = 16'h0000;
      if (ph % 3 == 1) hot_pages[1] = 16'hFFFF;
      for (int n = 0; n < PHASE_PAGES; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) page = hot_pages[$urandom_range(0, working_set - 1)];
        else if (pick == 8) page = 16'($urandom);
        else page = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        push_page(page);
      end
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("Checked %0d page references: %0d hits and %0d faults.",
             pages_accepted, hits_seen, faults_seen);
    $display("Frame count was set %0d times, including zero, one, eight and out-of-range values.",
             settings_written);
    if (failures == 0) begin
      $display("** lru_page_replacement: PASSED **");
    end else begin
      $display("** lru_page_replacement: FAILED **");
    end
    $finish;
  end

endmodule

// ===== lru_page_replacement.f =====
rtl/lrupr_pkg.sv
rtl/lrupr_frame_ram.sv
rtl/lru_page_replacement.sv
verif/lru_page_replacement_tb.sv
